// ===== hw/rtl/btpa_pkg.sv =====
`timescale 1ns / 1ps
package btpa_pkg;

    localparam int MAX_PAGES   = 1024;
    localparam int TREE_WORDS  = 2 * MAX_PAGES;
    localparam int NODE_W      = $clog2(TREE_WORDS);
    localparam int WORD_W      = 11;
    localparam int CNT_W       = 11;
    localparam int OFF_W       = 10;
    localparam int LG_W        = 4;
    localparam int SPAN_LG_MAX = $clog2(MAX_PAGES);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBLK = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SWEEP,
        CMD_BUILD_ROOT,
        CMD_BUILD_L,
        CMD_BUILD_R,
        CMD_RD_ROOT,
        CMD_CAP_ROOT,
        CMD_SPLIT_L,
        CMD_SPLIT_R,
        CMD_RD_L,
        CMD_RD_R,
        CMD_SEL,
        CMD_FAIL,
        CMD_CLR_NODE,
        CMD_UP,
        CMD_UP_R,
        CMD_UP_W,
        CMD_FREE_SET,
        CMD_RESULT
    } t_cmd;

    typedef struct packed {
        logic    bad;
        t_opcode op;
        logic    sweep_last;
        logic    build_more;
        logic    desc_more;
        logic    fit;
        logic    split;
        logic    sel_fail;
        logic    at_root;
        logic    out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/btpa_ram.sv =====
`timescale 1ns / 1ps
module btpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/btpa_dp.sv =====
`timescale 1ns / 1ps
module btpa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [btpa_pkg::WORD_W-1:0]  i_cfg_wdata,
    input  logic [btpa_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [1:0]                   i_s_tuser,
    input  btpa_pkg::t_cmd               i_cmd,
    input  logic                         i_m_tready,
    output btpa_pkg::t_dp_sts            o_sts,
    output logic                         o_m_tvalid,
    output logic [btpa_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]                   o_m_tuser
);
    import btpa_pkg::*;

    logic [LG_W-1:0]   r_cfg_lg;
    logic [WORD_W-1:0] r_cfg_usable;
    logic [LG_W-1:0]   r_span_lg;
    t_opcode           r_op;
    t_status           r_status;
    logic [WORD_W-1:0] r_want;
    logic [LG_W-1:0]   r_want_lg;
    logic [OFF_W-1:0]  r_off;
    logic [WORD_W-1:0] r_real;
    logic [WORD_W-1:0] r_v;
    logic [NODE_W-1:0] r_b;
    logic [WORD_W-1:0] r_bval;
    logic [WORD_W-1:0] r_len;
    logic [OFF_W-1:0]  r_begin;
    logic [WORD_W-1:0] r_lval;
    logic [WORD_W-1:0] r_free;
    logic [NODE_W-1:0] r_sweep;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [OFF_W-1:0]  r_out_off;
    logic [WORD_W-1:0] r_out_granted;
    logic [WORD_W-1:0] r_out_free;

    logic [WORD_W-1:0] span;
    t_opcode           in_op;
    logic [CNT_W-1:0]  in_cnt;
    logic [OFF_W-1:0]  in_off;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  smear;
    logic [WORD_W-1:0] in_len;
    logic [LG_W-1:0]   in_lg;
    logic              cnt_bad;
    logic              free_bad;
    logic              in_bad;
    logic [LG_W-1:0]   new_lg;
    logic [WORD_W-1:0] new_span;
    logic [WORD_W-1:0] v_half;
    logic [WORD_W-1:0] half;
    logic [NODE_W-1:0] node_l;
    logic [NODE_W-1:0] node_r;
    logic [NODE_W-1:0] node_free;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] merge;
    logic [WORD_W:0]   free_sum;
    logic              sel_l;
    logic              sel_r;
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;

    assign span   = WORD_W'(1) << r_span_lg;
    assign in_op  = t_opcode'(i_s_tuser);
    assign in_cnt = i_s_tdata[CNT_W-1:0];
    assign in_off = i_s_tdata[CNT_W+OFF_W-1:CNT_W];
    assign cnt_m1 = in_cnt - CNT_W'(1);

    always_comb begin
        in_lg = '0;
        for (int i = 0; i < CNT_W; i++) begin
            smear[i] = |(cnt_m1 >> i);
            in_lg    = in_lg + LG_W'(smear[i]);
        end
    end

    assign in_len   = smear + WORD_W'(1);
    assign cnt_bad  = (in_cnt == '0) || (in_cnt > span);
    assign free_bad = (|(in_off & smear[OFF_W-1:0]))
                   || (({2'b0, in_off} + {1'b0, in_len}) > {1'b0, span});

    always_comb begin
        case (in_op)
            OP_INIT:  in_bad = 1'b0;
            OP_ALLOC: in_bad = cnt_bad;
            OP_FREE:  in_bad = cnt_bad || free_bad;
            default:  in_bad = 1'b1;
        endcase
    end

    assign new_lg   = (r_cfg_lg > LG_W'(SPAN_LG_MAX)) ? LG_W'(SPAN_LG_MAX) : r_cfg_lg;
    assign new_span = WORD_W'(1) << new_lg;
    assign v_half   = r_v >> 1;
    assign half     = r_len >> 1;
    assign node_l   = {r_b[NODE_W-2:0], 1'b0};
    assign node_r   = {r_b[NODE_W-2:0], 1'b1};
    assign node_free = NODE_W'(({1'b0, span} + {2'b0, r_off}) >> r_want_lg);
    assign merge    = ((r_op == OP_FREE) && (r_lval == r_len) && (rdata == r_len))
                    ? (r_lval << 1) : (r_lval | rdata);
    assign free_sum = {1'b0, r_free} + {1'b0, r_want};

    assign sel_l = (|(r_want & r_lval)) ||
                   (!(|(r_want & rdata)) && (r_want <= r_lval));
    assign sel_r = !sel_l && ((|(r_want & rdata)) || (r_want <= rdata));

    always_comb begin
        we    = 1'b0;
        waddr = r_b;
        wdata = '0;
        raddr = r_b;
        case (i_cmd)
            CMD_SWEEP: begin
                we    = 1'b1;
                waddr = r_sweep;
            end
            CMD_BUILD_ROOT: begin
                we    = 1'b1;
                waddr = NODE_W'(1);
                wdata = r_real;
            end
            CMD_BUILD_L: begin
                we    = 1'b1;
                waddr = node_l;
                wdata = (r_real > v_half) ? v_half : r_real;
            end
            CMD_BUILD_R: begin
                we    = 1'b1;
                waddr = node_r;
                wdata = (r_real > v_half) ? (r_real - v_half) : '0;
            end
            CMD_RD_ROOT: raddr = NODE_W'(1);
            CMD_SPLIT_L: begin
                we    = 1'b1;
                waddr = node_l;
                wdata = r_bval >> 1;
            end
            CMD_SPLIT_R: begin
                we    = 1'b1;
                waddr = node_r;
                wdata = r_bval >> 1;
            end
            CMD_RD_L:     raddr = node_l;
            CMD_RD_R:     raddr = node_r;
            CMD_CLR_NODE: we = 1'b1;
            CMD_UP:       raddr = {r_b[NODE_W-1:1], 1'b0};
            CMD_UP_R:     raddr = {r_b[NODE_W-1:1], 1'b1};
            CMD_UP_W: begin
                we    = 1'b1;
                waddr = r_b >> 1;
                wdata = merge;
            end
            CMD_FREE_SET: begin
                we    = 1'b1;
                waddr = node_free;
                wdata = r_want;
            end
            default: ;
        endcase
    end

    btpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TREE_WORDS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lg     <= LG_W'(SPAN_LG_MAX);
            r_cfg_usable <= WORD_W'(MAX_PAGES);
            r_span_lg    <= LG_W'(SPAN_LG_MAX);
            r_free       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (!i_cfg_addr) begin
                    r_cfg_lg <= i_cfg_wdata[LG_W-1:0];
                end else begin
                    r_cfg_usable <= i_cfg_wdata;
                end
            end
            if (i_cmd == CMD_LOAD && in_op == OP_INIT) begin
                r_span_lg <= new_lg;
            end
            case (i_cmd)
                CMD_BUILD_ROOT: r_free <= r_real;
                CMD_CLR_NODE:   r_free <= (r_free >= r_want) ? (r_free - r_want) : '0;
                CMD_FREE_SET:   r_free <= (free_sum > {1'b0, span}) ? span
                                                                    : free_sum[WORD_W-1:0];
                default: ;
            endcase
            if (i_cmd == CMD_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_op      <= in_op;
                r_want    <= in_len;
                r_want_lg <= in_lg;
                r_off     <= in_off;
                r_status  <= in_bad ? ST_BAD : ST_OK;
                r_sweep   <= '0;
                r_begin   <= '0;
                r_real    <= (r_cfg_usable < new_span) ? r_cfg_usable : new_span;
            end
            CMD_SWEEP: r_sweep <= r_sweep + NODE_W'(1);
            CMD_BUILD_ROOT: begin
                r_b <= NODE_W'(1);
                r_v <= span;
            end
            CMD_BUILD_R: begin
                if (r_real > v_half) begin
                    r_real <= r_real - v_half;
                    r_b    <= node_r;
                end else begin
                    r_b <= node_l;
                end
                r_v <= v_half;
            end
            CMD_CAP_ROOT: begin
                r_bval  <= rdata;
                r_b     <= NODE_W'(1);
                r_len   <= span;
            end
            CMD_SPLIT_R: begin
                r_b    <= node_l;
                r_bval <= r_bval >> 1;
                r_len  <= half;
            end
            CMD_RD_R: r_lval <= rdata;
            CMD_SEL: begin
                if (sel_l) begin
                    r_b    <= node_l;
                    r_bval <= r_lval;
                end else begin
                    r_b     <= node_r;
                    r_bval  <= rdata;
                    r_begin <= r_begin + half[OFF_W-1:0];
                end
                r_len <= half;
            end
            CMD_FAIL: r_status <= ST_NOBLK;
            CMD_UP_R: r_lval <= rdata;
            CMD_UP_W: begin
                r_b   <= r_b >> 1;
                r_len <= r_len << 1;
            end
            CMD_FREE_SET: begin
                r_b   <= node_free;
                r_len <= r_want;
            end
            CMD_RESULT: begin
                r_out_status  <= r_status;
                r_out_off     <= (r_status == ST_OK && r_op == OP_ALLOC) ? r_begin : '0;
                r_out_granted <= (r_status == ST_OK && r_op != OP_INIT) ? r_want : '0;
                r_out_free    <= r_free;
            end
            default: ;
        endcase
    end

    assign o_sts.bad        = (r_status != ST_OK);
    assign o_sts.op         = r_op;
    assign o_sts.sweep_last = &r_sweep;
    assign o_sts.build_more = (r_real != '0) && (r_real < r_v);
    assign o_sts.desc_more  = (r_want <= r_bval) && (r_want < r_len);
    assign o_sts.fit        = (r_want <= r_bval);
    assign o_sts.split      = (r_bval == r_len);
    assign o_sts.sel_fail   = !sel_l && !sel_r;
    assign o_sts.at_root    = (r_b == NODE_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_free, r_out_granted, r_out_off};
    assign o_m_tuser  = r_out_status;
endmodule

// ===== hw/rtl/btpa_ctrl.sv =====
`timescale 1ns / 1ps
module btpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  btpa_pkg::t_dp_sts i_sts,
    output btpa_pkg::t_cmd    o_cmd,
    output logic              o_s_tready
);
    import btpa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_BUILD_ROOT,
        S_BUILD_CHK,
        S_BUILD_L,
        S_BUILD_R,
        S_RD_ROOT,
        S_CAP_ROOT,
        S_CHK,
        S_SPLIT_L,
        S_SPLIT_R,
        S_RD_L,
        S_RD_R,
        S_SEL,
        S_FAIL,
        S_CLR_NODE,
        S_UP,
        S_UP_R,
        S_UP_W,
        S_FREE_SET,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd     = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.bad) begin
                    n_state = S_FINISH;
                end else if (i_sts.op == OP_INIT) begin
                    n_state = S_SWEEP;
                end else if (i_sts.op == OP_ALLOC) begin
                    n_state = S_RD_ROOT;
                end else begin
                    n_state = S_FREE_SET;
                end
            end
            S_SWEEP: begin
                cmd = CMD_SWEEP;
                if (i_sts.sweep_last) begin
                    n_state = S_BUILD_ROOT;
                end
            end
            S_BUILD_ROOT: begin
                cmd     = CMD_BUILD_ROOT;
                n_state = S_BUILD_CHK;
            end
            S_BUILD_CHK: begin
                n_state = i_sts.build_more ? S_BUILD_L : S_FINISH;
            end
            S_BUILD_L: begin
                cmd     = CMD_BUILD_L;
                n_state = S_BUILD_R;
            end
            S_BUILD_R: begin
                cmd     = CMD_BUILD_R;
                n_state = S_BUILD_CHK;
            end
            S_RD_ROOT: begin
                cmd     = CMD_RD_ROOT;
                n_state = S_CAP_ROOT;
            end
            S_CAP_ROOT: begin
                cmd     = CMD_CAP_ROOT;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.desc_more) begin
                    n_state = i_sts.split ? S_SPLIT_L : S_RD_L;
                end else begin
                    n_state = i_sts.fit ? S_CLR_NODE : S_FAIL;
                end
            end
            S_SPLIT_L: begin
                cmd     = CMD_SPLIT_L;
                n_state = S_SPLIT_R;
            end
            S_SPLIT_R: begin
                cmd     = CMD_SPLIT_R;
                n_state = S_CHK;
            end
            S_RD_L: begin
                cmd     = CMD_RD_L;
                n_state = S_RD_R;
            end
            S_RD_R: begin
                cmd     = CMD_RD_R;
                n_state = S_SEL;
            end
            S_SEL: begin
                if (i_sts.sel_fail) begin
                    n_state = S_FAIL;
                end else begin
                    cmd     = CMD_SEL;
                    n_state = S_CHK;
                end
            end
            S_FAIL: begin
                cmd     = CMD_FAIL;
                n_state = S_FINISH;
            end
            S_CLR_NODE: begin
                cmd     = CMD_CLR_NODE;
                n_state = S_UP;
            end
            S_UP: begin
                if (i_sts.at_root) begin
                    n_state = S_FINISH;
                end else begin
                    cmd     = CMD_UP;
                    n_state = S_UP_R;
                end
            end
            S_UP_R: begin
                cmd     = CMD_UP_R;
                n_state = S_UP_W;
            end
            S_UP_W: begin
                cmd     = CMD_UP_W;
                n_state = S_UP;
            end
            S_FREE_SET: begin
                cmd     = CMD_FREE_SET;
                n_state = S_UP;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd     = CMD_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_s_tready = (r_state == S_IDLE);
endmodule

// ===== hw/rtl/buddy_tree_page_allocator.sv =====
// Channel  | Dir | Signals                        | Contents (lowest bit first)
// cfg      | in  | i_cfg_we, i_cfg_addr, i_cfg_wdata | 0 tree_size_log2, 1 usable_pages
// request  | in  | s_axis_tvalid/tready/tdata/tuser | tuser opcode; tdata count, offset
// result   | out | m_axis_tvalid/tready/tdata/tuser | tuser status; tdata offset, granted, free
//
// One request in flight; the next transfer is taken while a result still waits.
// Request transfer to result load is tree RAM port bound. Alloc: root read, per level down
// a split or a read of both children, per level up a parent rewrite. Free: node set, per
// level up a parent rewrite. Init: clear all 2048 RAM words, a build step per level. Bad
// requests skip to the result load, which stalls while a result still waits.
// Synchronous active-low reset; the tree holds no data until the first init.
`timescale 1ns / 1ps
module buddy_tree_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // page_count[10:0], page_offset[20:11], zero pad
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // block_offset[9:0], granted_pages[20:10],
                                       // free_left[31:21]
    output logic [1:0]  m_axis_tuser   // status
);
    import btpa_pkg::*;

    t_cmd    cmd;
    t_dp_sts sts;

    btpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_s_tready (s_axis_tready)
    );

    btpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cmd       (cmd),
        .i_m_tready  (m_axis_tready),
        .o_sts       (sts),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );
endmodule

// ===== verif/tb_buddy_tree_page_allocator.sv =====
`timescale 1ns / 1ps
module tb_buddy_tree_page_allocator;
    import btpa_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  block_offset;
        logic [10:0] granted_pages;
        logic [10:0] free_left;
    } t_result;

    class alloc_scoreboard;
        logic [10:0] tree[TREE_WORDS];
        int          free_cnt;
        int          span;
        int          lg_reg;
        int          usable_reg;
        t_result     pending[$];
        int          errors;

        function new();
            foreach (tree[i]) tree[i] = '0;
            free_cnt   = 0;
            lg_reg     = 10;
            usable_reg = 1024;
            span       = range_of(lg_reg);
            errors     = 0;
        endfunction

        function int range_of(int lg);
            int want;
            want = 1 << (lg & 15);
            return (want < MAX_PAGES) ? want : MAX_PAGES;
        endfunction

        function int rd(int i);
            return (i < TREE_WORDS) ? int'(tree[i]) : 0;
        endfunction

        function void wr(int i, int v);
            if (i < TREE_WORDS) tree[i] = v[10:0];
        endfunction

        function void set_reg(logic idx, logic [10:0] v);
            if (idx == 1'b0) lg_reg = v & 15;
            else usable_reg = v;
        endfunction

        function void build();
            int real_pg, v, b;
            span    = range_of(lg_reg);
            v       = span;
            real_pg = (usable_reg < span) ? usable_reg : span;
            foreach (tree[i]) tree[i] = '0;
            free_cnt = real_pg;
            b = 1;
            wr(b, real_pg);
            while (real_pg > 0 && real_pg < v) begin
                v = v >> 1;
                if (real_pg > v) begin
                    wr(2 * b, v);
                    real_pg -= v;
                    wr(2 * b + 1, real_pg);
                    b = 2 * b + 1;
                end else begin
                    wr(2 * b, real_pg);
                    wr(2 * b + 1, 0);
                    b = 2 * b;
                end
            end
        endfunction

        function bit take(int want, output int where);
            int b, len, start, l, r, half;
            b = 1; len = span; start = 0; where = 0;
            if (want > rd(b)) return 1'b0;
            while (want <= rd(b) && want < len) begin
                l = 2 * b; r = l + 1; half = len >> 1;
                if (rd(b) == len) begin
                    wr(l, rd(b) >> 1);
                    wr(r, rd(b) >> 1);
                    b = l;
                end else if ((want & rd(l)) != 0) begin
                    b = l;
                end else if ((want & rd(r)) != 0) begin
                    b = r; start += half;
                end else if (want <= rd(l)) begin
                    b = l;
                end else if (want <= rd(r)) begin
                    b = r; start += half;
                end else begin
                    return 1'b0;
                end
                len = half;
            end
            if (want > rd(b)) return 1'b0;
            wr(b, 0);
            free_cnt = (free_cnt >= want) ? free_cnt - want : 0;
            while (b != 1) begin
                b = b >> 1;
                wr(b, rd(2 * b) | rd(2 * b + 1));
            end
            where = start;
            return 1'b1;
        endfunction

        function void release_blk(int start, int len);
            int b;
            b = (span + start) / len;
            wr(b, len);
            free_cnt += len;
            if (free_cnt > span) free_cnt = span;
            while (b != 1) begin
                b = b >> 1;
                if (rd(2 * b) == len && rd(2 * b + 1) == len) wr(b, rd(2 * b) << 1);
                else wr(b, rd(2 * b) | rd(2 * b + 1));
                len = len << 1;
            end
        endfunction

        // note an accepted request, returns the expected result
        function t_result note_request(t_opcode op, int cnt, int off);
            t_result res;
            int      len, where;
            res = '0;
            if (op == OP_INIT) begin
                build();
            end else if (op == OP_ALLOC || op == OP_FREE) begin
                if (cnt == 0 || cnt > span) begin
                    res.status = ST_BAD;
                end else begin
                    len = 1;
                    while (len < cnt) len = len << 1;
                    if (op == OP_ALLOC) begin
                        if (take(len, where)) begin
                            res.block_offset  = 10'(where);
                            res.granted_pages = 11'(len);
                        end else begin
                            res.status = ST_NOBLK;
                        end
                    end else if ((off & (len - 1)) != 0 || off + len > span) begin
                        res.status = ST_BAD;
                    end else begin
                        release_blk(off, len);
                        res.granted_pages = 11'(len);
                    end
                end
            end else begin
                res.status = ST_BAD;
            end
            res.free_left = 11'(free_cnt);
            pending.push_back(res);
            return res;
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.block_offset !== exp.block_offset) begin
                $error("block_offset: expected %0d, got %0d",
                       exp.block_offset, got.block_offset);
                errors++;
            end
            if (got.granted_pages !== exp.granted_pages) begin
                $error("granted_pages: expected %0d, got %0d",
                       exp.granted_pages, got.granted_pages);
                errors++;
            end
            if (got.free_left !== exp.free_left) begin
                $error("free_left: expected %0d, got %0d",
                       exp.free_left, got.free_left);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alloc_scoreboard sb;
    bit              no_gaps;
    int              stall_cnt;
    int              rdy_wait;
    int              held_off[$];
    int              held_len[$];

    buddy_tree_page_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: check each transfer, then draw the idle cycles before the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rdy_wait = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sb.check_result({m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[20:10],
                             m_axis_tdata[31:21]});
            rdy_wait = no_gaps ? 0 : $urandom_range(0, 18);
            m_axis_tready <= (rdy_wait == 0);
        end else if (!m_axis_tready) begin
            if (rdy_wait > 0) rdy_wait--;
            if (rdy_wait == 0) m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic send(t_opcode op, int cnt, int off);
        t_result res;
        int      gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, off[9:0], cnt[10:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        res = sb.note_request(op, cnt[10:0], off[9:0]);
        if (op == OP_INIT) begin
            held_off.delete();
            held_len.delete();
        end else if (op == OP_ALLOC && res.status == ST_OK) begin
            held_off.push_back(res.block_offset);
            held_len.push_back(res.granted_pages);
        end
    endtask

    task automatic random_item();
        int k, sel, len, cap;
        sel = $urandom_range(0, 99);
        cap = (sb.span < 8) ? sb.span : 8;
        if (sel < 45) begin
            if ($urandom_range(0, 9) == 0) send(OP_ALLOC, $urandom_range(1, sb.span), 0);
            else send(OP_ALLOC, $urandom_range(1, cap), $urandom_range(0, 1023));
        end else if (sel < 80 && held_off.size() > 0) begin
            k   = $urandom_range(0, held_off.size() - 1);
            len = held_len[k];
            send(OP_FREE, (len == 1) ? 1 : $urandom_range(len / 2 + 1, len), held_off[k]);
            if ($urandom_range(0, 19) != 0) begin
                held_off.delete(k);
                held_len.delete(k);
            end
        end else if (sel < 88) begin
            len = 1 << $urandom_range(0, 3);
            send(OP_FREE, len, $urandom_range(0, 1023) & ~(len - 1) % (sb.span + 1));
        end else if (sel < 94) begin
            send(t_opcode'(OP_ALLOC + $urandom_range(0, 1)), $urandom_range(0, 2047),
                 $urandom_range(0, 1023));
        end else if (sel < 97) begin
            send(OP_RSVD, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end else begin
            send(OP_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        int lg_set[9]     = '{10, 0, 0, 3, 10, 15, 4, 6, 2};
        int usable_set[9] = '{1024, 0, 1, 5, 1000, 2047, 16, 37, 4};
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INIT;
        no_gaps       = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full range at reset values
        send(OP_INIT, 0, 0);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 1025, 0);
        send(OP_ALLOC, 2047, 1023);
        send(OP_RSVD, 1, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_ALLOC, 3, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_FREE, 2, 1);
        send(OP_FREE, 2, 1023);
        send(OP_FREE, 1, 1023);
        send(OP_FREE, 1, 0);
        send(OP_FREE, 1, 0);
        send(OP_ALLOC, 512, 0);
        send(OP_ALLOC, 512, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_FREE, 1024, 0);
        send(OP_FREE, 0, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_FREE, 1024, 0);

        for (int p = 0; p < 9; p++) begin
            wait_drained();
            write_reg(1'b0, 11'(lg_set[p]));
            write_reg(1'b1, 11'(usable_set[p]));
            no_gaps = (p % 3 == 2);
            send(OP_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
            for (int n = 0; n < 65; n++) begin
                if (p == 4 && n == 30) wait_drained();
                random_item();
            end
        end
        no_gaps = 1'b0;
        wait_drained();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
